>>> design/qdme_pkg.sv
// Shared types and constants of the quote delta mask encoder.
`default_nettype none
package qdme_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned ScaleW = 63;

  localparam logic [2:0] SID_TIME = 3'd0;
  localparam logic [2:0] SID_MASK = 3'd1;
  localparam logic [2:0] SID_BID = 3'd2;
  localparam logic [2:0] SID_SPREAD = 3'd3;
  localparam logic [2:0] SID_BID_QTY = 3'd4;
  localparam logic [2:0] SID_ASK_QTY = 3'd5;
  localparam logic [2:0] SID_BASE = 3'd6;

  localparam logic [1:0] REG_TIME_SCALE = 2'd0;
  localparam logic [1:0] REG_PRICE_SCALE = 2'd1;
  localparam logic [1:0] REG_QTY_SCALE = 2'd2;
  localparam logic [1:0] REG_PACKED_MASKS = 2'd3;

  typedef struct packed {
    logic [WordW-1:0] ts;
    logic [WordW-1:0] bid;
    logic [WordW-1:0] spr;
    logic [WordW-1:0] bq;
    logic [WordW-1:0] aq;
    logic first;
    logic fin;
  } rec_t;

  function automatic logic [WordW-1:0] zigzag(input logic [WordW-1:0] v);
    return {v[WordW-2:0], 1'b0} ^ {WordW{v[WordW-1]}};
  endfunction

endpackage
`default_nettype wire

>>> design/qdme_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module qdme_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [qdme_pkg::WordW-1:0]    dividend_i,
  input  wire logic [qdme_pkg::ScaleW-1:0]   divisor_i,
  output logic                               done_o,
  output logic [qdme_pkg::WordW-1:0]         quot_o
);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic                         neg_q, neg_d;
  logic [6:0]                   cnt_q, cnt_d;
  logic [qdme_pkg::WordW-1:0]   a_q, a_d;
  logic [qdme_pkg::WordW-1:0]   r_q, r_d;
  logic [qdme_pkg::ScaleW-1:0]  d_q, d_d;
  logic [qdme_pkg::WordW-1:0]   rs;
  logic [qdme_pkg::WordW-1:0]   dext;

  assign rs = {r_q[qdme_pkg::WordW-2:0], a_q[qdme_pkg::WordW-1]};
  assign dext = {1'b0, d_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d = neg_q;
    cnt_d = cnt_q;
    a_d = a_q;
    r_d = r_q;
    d_d = d_q;
    if (start_i) begin
      busy_d = 1'b1;
      neg_d = dividend_i[qdme_pkg::WordW-1];
      a_d = dividend_i[qdme_pkg::WordW-1] ? (~dividend_i + 64'd1) : dividend_i;
      r_d = '0;
      cnt_d = '0;
      d_d = (divisor_i == '0) ? 63'd1 : divisor_i;
    end else if (busy_q) begin
      if (rs >= dext) begin
        r_d = rs - dext;
        a_d = {a_q[qdme_pkg::WordW-2:0], 1'b1};
      end else begin
        r_d = rs;
        a_d = {a_q[qdme_pkg::WordW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    a_q <= a_d;
    r_q <= r_d;
    d_q <= d_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? (~a_q + 64'd1) : a_q;

endmodule
`default_nettype wire

>>> design/qdme_front.sv
// Front end: accepts records, forms the spread and scales the five values.
`default_nettype none
module qdme_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push_i,
  output logic                              full_o,
  input  wire logic [qdme_pkg::WordW-1:0]   bid_price_i,
  input  wire logic [qdme_pkg::WordW-1:0]   bid_amount_i,
  input  wire logic [qdme_pkg::WordW-1:0]   ask_price_i,
  input  wire logic [qdme_pkg::WordW-1:0]   ask_amount_i,
  input  wire logic [qdme_pkg::WordW-1:0]   stamp_i,
  input  wire logic                         first_record_i,
  input  wire logic                         final_record_i,
  input  wire logic [qdme_pkg::ScaleW-1:0]  time_scale_i,
  input  wire logic [qdme_pkg::ScaleW-1:0]  price_scale_i,
  input  wire logic [qdme_pkg::ScaleW-1:0]  qty_scale_i,
  output logic                              q_push_o,
  input  wire logic                         q_full_i,
  output qdme_pkg::rec_t                    q_rec_o
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } fstate_e;

  fstate_e                      state_q, state_d;
  logic [2:0]                   idx_q, idx_d;
  logic                         start_q, start_d;
  logic [qdme_pkg::WordW-1:0]   bid_q, bq_q, spr_q, aq_q, ts_q;
  logic                         first_q, fin_q;
  qdme_pkg::rec_t               rec_q, rec_d;
  logic [qdme_pkg::WordW-1:0]   op_raw;
  logic [qdme_pkg::ScaleW-1:0]  op_scale;
  logic                         div_done;
  logic [qdme_pkg::WordW-1:0]   div_quot;
  logic                         accept;

  assign accept = push_i && (state_q == F_IDLE);

  always_comb begin
    case (idx_q)
      3'd1: begin
        op_raw = bid_q;
        op_scale = price_scale_i;
      end
      3'd2: begin
        op_raw = spr_q;
        op_scale = price_scale_i;
      end
      3'd3: begin
        op_raw = bq_q;
        op_scale = qty_scale_i;
      end
      3'd4: begin
        op_raw = aq_q;
        op_scale = qty_scale_i;
      end
      default: begin
        op_raw = ts_q;
        op_scale = time_scale_i;
      end
    endcase
  end

  qdme_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .dividend_i (op_raw),
    .divisor_i  (op_scale),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    start_d = 1'b0;
    rec_d = rec_q;
    unique case (state_q)
      F_IDLE: begin
        if (push_i) begin
          state_d = F_DIV;
          idx_d = '0;
          start_d = 1'b1;
        end
      end
      F_DIV: begin
        if (div_done) begin
          case (idx_q)
            3'd1: rec_d.bid = div_quot;
            3'd2: rec_d.spr = div_quot;
            3'd3: rec_d.bq = div_quot;
            3'd4: rec_d.aq = div_quot;
            default: rec_d.ts = div_quot;
          endcase
          if (idx_q == 3'd4) begin
            state_d = F_PUSH;
          end else begin
            idx_d = idx_q + 3'd1;
            start_d = 1'b1;
          end
        end
      end
      F_PUSH: begin
        if (!q_full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
    rec_d.first = first_q;
    rec_d.fin = fin_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      idx_q <= '0;
      start_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      start_q <= start_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
    if (accept) begin
      bid_q <= bid_price_i;
      bq_q <= bid_amount_i;
      aq_q <= ask_amount_i;
      ts_q <= stamp_i;
      spr_q <= ask_price_i - bid_price_i;
      first_q <= first_record_i;
      fin_q <= final_record_i;
    end
  end

  assign full_o = (state_q != F_IDLE);
  assign q_push_o = (state_q == F_PUSH) && !q_full_i;
  assign q_rec_o = rec_q;

endmodule
`default_nettype wire

>>> design/qdme_queue.sv
// Two-entry queue of scaled records between the front and back ends.
`default_nettype none
module qdme_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire qdme_pkg::rec_t  rec_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output qdme_pkg::rec_t       rec_o
);

  qdme_pkg::rec_t  mem_q [2];
  logic            wptr_q, rptr_q;
  logic [1:0]      cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  assign full_o = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rec_o = mem_q[rptr_q];

endmodule
`default_nettype wire

>>> design/qdme_back.sv
// Back end: keeps the delta state and serializes base words, varints and masks.
`default_nettype none
module qdme_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        q_empty_i,
  input  wire qdme_pkg::rec_t              q_rec_i,
  output logic                             q_pop_o,
  input  wire logic                        packed_i,
  output logic                             empty_o,
  input  wire logic                        pop_i,
  output logic [2:0]                       stream_id_o,
  output logic [7:0]                       data_byte_o,
  output logic [qdme_pkg::WordW-1:0]       base_word_o,
  output logic                             last_o
);

  typedef enum logic [5:0] {
    B_IDLE  = 6'b000001,
    B_BASE  = 6'b000010,
    B_VAR   = 6'b000100,
    B_MASK  = 6'b001000,
    B_SEL   = 6'b010000,
    B_FLUSH = 6'b100000
  } bstate_e;

  bstate_e                     state_q, state_d;
  qdme_pkg::rec_t              rec_q, rec_d;
  logic [qdme_pkg::WordW-1:0]  pts_q, pbid_q, pspr_q, pbq_q, paq_q;
  logic [qdme_pkg::WordW-1:0]  zz0_q, zz1_q, zz2_q, zz3_q, zz0_d, zz1_d, zz2_d, zz3_d;
  logic [qdme_pkg::WordW-1:0]  v_q, v_d;
  logic [2:0]                  sid_q, sid_d;
  logic [2:0]                  k_q, k_d;
  logic [3:0]                  rem_q, rem_d;
  logic                        memit_q, memit_d, fl_q, fl_d;
  logic [7:0]                  mbyte_q, mbyte_d, fbyte_q, fbyte_d;
  logic [3:0]                  held_q, held_d;
  logic                        nw_q, nw_d;
  logic                        load;
  logic [qdme_pkg::WordW-1:0]  d_t, d_b, d_s, d_bq, d_aq;
  logic [3:0]                  m;
  logic                        nw_after;
  logic [3:0]                  held_after;
  logic                        slot;
  logic                        emit, e_last;
  logic [2:0]                  e_sid;
  logic [7:0]                  e_byte;
  logic [qdme_pkg::WordW-1:0]  e_word;
  logic                        ov_q;
  logic [2:0]                  osid_q;
  logic [7:0]                  obyte_q;
  logic [qdme_pkg::WordW-1:0]  oword_q;
  logic                        olast_q;
  logic                        v_small;

  assign slot = !ov_q || pop_i;
  assign load = (state_q == B_IDLE) && !q_empty_i;
  assign d_t = q_rec_i.ts - pts_q;
  assign d_b = q_rec_i.bid - pbid_q;
  assign d_s = q_rec_i.spr - pspr_q;
  assign d_bq = q_rec_i.bq - pbq_q;
  assign d_aq = q_rec_i.aq - paq_q;
  assign m = {d_aq != '0, d_bq != '0, d_s != '0, d_b != '0};
  assign nw_after = packed_i ? !nw_q : nw_q;
  assign held_after = packed_i ? (nw_q ? 4'd0 : m) : held_q;
  assign v_small = (v_q[qdme_pkg::WordW-1:7] == '0);

  always_comb begin
    state_d = state_q;
    rec_d = rec_q;
    zz0_d = zz0_q;
    zz1_d = zz1_q;
    zz2_d = zz2_q;
    zz3_d = zz3_q;
    v_d = v_q;
    sid_d = sid_q;
    k_d = k_q;
    rem_d = rem_q;
    memit_d = memit_q;
    fl_d = fl_q;
    mbyte_d = mbyte_q;
    fbyte_d = fbyte_q;
    held_d = held_q;
    nw_d = nw_q;
    emit = 1'b0;
    e_last = 1'b0;
    e_sid = qdme_pkg::SID_MASK;
    e_byte = '0;
    e_word = '0;
    unique case (state_q)
      B_IDLE: begin
        if (load) begin
          rec_d = q_rec_i;
          if (q_rec_i.first) begin
            nw_d = 1'b0;
            held_d = '0;
            k_d = '0;
            state_d = B_BASE;
          end else begin
            zz0_d = qdme_pkg::zigzag(d_b);
            zz1_d = qdme_pkg::zigzag(d_s);
            zz2_d = qdme_pkg::zigzag(d_bq);
            zz3_d = qdme_pkg::zigzag(d_aq);
            memit_d = !packed_i || nw_q;
            mbyte_d = packed_i ? {m, held_q} : {4'd0, m};
            fl_d = q_rec_i.fin && nw_after;
            fbyte_d = {4'd0, held_after};
            if (q_rec_i.fin && nw_after) begin
              nw_d = 1'b0;
              held_d = '0;
            end else begin
              nw_d = nw_after;
              held_d = held_after;
            end
            v_d = d_t;
            sid_d = qdme_pkg::SID_TIME;
            rem_d = m;
            state_d = B_VAR;
          end
        end
      end
      B_BASE: begin
        if (slot) begin
          emit = 1'b1;
          e_sid = qdme_pkg::SID_BASE;
          e_last = (k_q == 3'd4);
          case (k_q)
            3'd1: e_word = rec_q.bid;
            3'd2: e_word = rec_q.spr;
            3'd3: e_word = rec_q.bq;
            3'd4: e_word = rec_q.aq;
            default: e_word = rec_q.ts;
          endcase
          if (k_q == 3'd4) begin
            state_d = B_IDLE;
          end else begin
            k_d = k_q + 3'd1;
          end
        end
      end
      B_VAR: begin
        if (slot) begin
          emit = 1'b1;
          e_sid = sid_q;
          e_byte = {!v_small, v_q[6:0]};
          if (sid_q == qdme_pkg::SID_TIME) begin
            e_last = v_small && !memit_q && (rem_q == '0) && !fl_q;
          end else begin
            e_last = v_small && (rem_q == '0) && !fl_q;
          end
          if (!v_small) begin
            v_d = {7'd0, v_q[qdme_pkg::WordW-1:7]};
          end else if (sid_q == qdme_pkg::SID_TIME) begin
            state_d = B_MASK;
          end else begin
            state_d = B_SEL;
          end
        end
      end
      B_MASK: begin
        if (!memit_q) begin
          state_d = B_SEL;
        end else if (slot) begin
          emit = 1'b1;
          e_sid = qdme_pkg::SID_MASK;
          e_byte = mbyte_q;
          e_last = (rem_q == '0) && !fl_q;
          state_d = B_SEL;
        end
      end
      B_SEL: begin
        priority if (rem_q[0]) begin
          v_d = zz0_q;
          sid_d = qdme_pkg::SID_BID;
          rem_d = {rem_q[3:1], 1'b0};
          state_d = B_VAR;
        end else if (rem_q[1]) begin
          v_d = zz1_q;
          sid_d = qdme_pkg::SID_SPREAD;
          rem_d = {rem_q[3:2], 2'b0};
          state_d = B_VAR;
        end else if (rem_q[2]) begin
          v_d = zz2_q;
          sid_d = qdme_pkg::SID_BID_QTY;
          rem_d = {rem_q[3], 3'b0};
          state_d = B_VAR;
        end else if (rem_q[3]) begin
          v_d = zz3_q;
          sid_d = qdme_pkg::SID_ASK_QTY;
          rem_d = '0;
          state_d = B_VAR;
        end else if (fl_q) begin
          state_d = B_FLUSH;
        end else begin
          state_d = B_IDLE;
        end
      end
      B_FLUSH: begin
        if (slot) begin
          emit = 1'b1;
          e_sid = qdme_pkg::SID_MASK;
          e_byte = fbyte_q;
          e_last = 1'b1;
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      ov_q <= 1'b0;
      nw_q <= 1'b0;
      held_q <= '0;
      pts_q <= '0;
      pbid_q <= '0;
      pspr_q <= '0;
      pbq_q <= '0;
      paq_q <= '0;
    end else begin
      state_q <= state_d;
      nw_q <= nw_d;
      held_q <= held_d;
      if (emit) begin
        ov_q <= 1'b1;
      end else if (pop_i) begin
        ov_q <= 1'b0;
      end
      if (load) begin
        pts_q <= q_rec_i.ts;
        pbid_q <= q_rec_i.bid;
        pspr_q <= q_rec_i.spr;
        pbq_q <= q_rec_i.bq;
        paq_q <= q_rec_i.aq;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
    zz0_q <= zz0_d;
    zz1_q <= zz1_d;
    zz2_q <= zz2_d;
    zz3_q <= zz3_d;
    v_q <= v_d;
    sid_q <= sid_d;
    k_q <= k_d;
    rem_q <= rem_d;
    memit_q <= memit_d;
    fl_q <= fl_d;
    mbyte_q <= mbyte_d;
    fbyte_q <= fbyte_d;
    if (emit) begin
      osid_q <= e_sid;
      obyte_q <= e_byte;
      oword_q <= e_word;
      olast_q <= e_last;
    end
  end

  assign q_pop_o = load;
  assign empty_o = !ov_q;
  assign stream_id_o = osid_q;
  assign data_byte_o = obyte_q;
  assign base_word_o = oword_q;
  assign last_o = olast_q;

endmodule
`default_nettype wire

>>> design/quote_delta_mask_encoder_core.sv
// Top level of the quote delta mask encoder with its configuration registers.
// Each record is scaled by one shared radix-2 divider that runs five divisions
// in turn, so the front end takes no new record until all five are done and the
// record is pushed; the back end then emits at most one coded byte or base word
// per cycle while pop is held, with no output while it loads each record, skips
// a mask that is not sent or selects each changed field, and a two-entry queue
// between them lets the next record be scaled meanwhile.
`default_nettype none
module quote_delta_mask_encoder_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push,
  output logic              full,
  input  wire logic [63:0]  bid_price_i,
  input  wire logic [63:0]  bid_amount_i,
  input  wire logic [63:0]  ask_price_i,
  input  wire logic [63:0]  ask_amount_i,
  input  wire logic [63:0]  stamp_i,
  input  wire logic         first_record_i,
  input  wire logic         final_record_i,
  output logic              empty,
  input  wire logic         pop,
  output logic [2:0]        stream_id_o,
  output logic [7:0]        data_byte_o,
  output logic [63:0]       base_word_o,
  output logic              last_o,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [1:0]   cfg_index_i,
  input  wire logic [63:0]  cfg_data_i
);

  logic [qdme_pkg::ScaleW-1:0]  time_scale_q, price_scale_q, qty_scale_q;
  logic                         packed_q;
  logic                         q_push, q_full, q_pop, q_empty;
  qdme_pkg::rec_t               q_in, q_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_scale_q <= 63'd1;
      price_scale_q <= 63'd1;
      qty_scale_q <= 63'd1;
      packed_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        qdme_pkg::REG_TIME_SCALE:   time_scale_q <= cfg_data_i[62:0];
        qdme_pkg::REG_PRICE_SCALE:  price_scale_q <= cfg_data_i[62:0];
        qdme_pkg::REG_QTY_SCALE:    qty_scale_q <= cfg_data_i[62:0];
        qdme_pkg::REG_PACKED_MASKS: packed_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  qdme_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .bid_price_i    (bid_price_i),
    .bid_amount_i   (bid_amount_i),
    .ask_price_i    (ask_price_i),
    .ask_amount_i   (ask_amount_i),
    .stamp_i        (stamp_i),
    .first_record_i (first_record_i),
    .final_record_i (final_record_i),
    .time_scale_i   (time_scale_q),
    .price_scale_i  (price_scale_q),
    .qty_scale_i    (qty_scale_q),
    .q_push_o       (q_push),
    .q_full_i       (q_full),
    .q_rec_o        (q_in)
  );

  qdme_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .rec_i   (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .rec_o   (q_out)
  );

  qdme_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_rec_i     (q_out),
    .q_pop_o     (q_pop),
    .packed_i    (packed_q),
    .empty_o     (empty),
    .pop_i       (pop),
    .stream_id_o (stream_id_o),
    .data_byte_o (data_byte_o),
    .base_word_o (base_word_o),
    .last_o      (last_o)
  );

endmodule
`default_nettype wire

>>> tb/tb_quote_delta_mask_encoder_core.sv
// Testbench for the quote delta mask encoder core: random and directed records against a predictor.
`timescale 1ns / 100ps
module tb_quote_delta_mask_encoder_core;

  typedef struct packed {
    logic [2:0] sid;
    logic [7:0] byte_v;
    logic [63:0] word;
    logic lst;
  } coded_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [63:0] bid_price_i = '0, bid_amount_i = '0, ask_price_i = '0;
  logic [63:0] ask_amount_i = '0, stamp_i = '0;
  logic first_record_i = 1'b0, final_record_i = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [2:0] stream_id_o;
  logic [7:0] data_byte_o;
  logic [63:0] base_word_o;
  logic last_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  quote_delta_mask_encoder_core dut (.*);

  always #2 clk_i = ~clk_i;

  logic [62:0] k_time, k_price, k_qty;
  logic k_packed;
  logic [63:0] p_time, p_bid, p_spr, p_bq, p_aq;
  logic [3:0] p_nib;
  logic p_wait;
  coded_t coded_q[$];
  int errors = 0;
  longint cycles = 0;
  logic [63:0] stamp_run = 0;
  int pop_hold = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 64'd30000000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report(input string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  always @(posedge clk_i) begin
    coded_t e;
    if (rst_ni && pop && !empty) begin
      if (coded_q.size() == 0) report("beat with nothing expected");
      else begin
        e = coded_q.pop_front();
        if (stream_id_o !== e.sid) report($sformatf("sid %0d exp %0d", stream_id_o, e.sid));
        if (data_byte_o !== e.byte_v) report($sformatf("byte %h exp %h", data_byte_o, e.byte_v));
        if (base_word_o !== e.word) report($sformatf("word %h exp %h", base_word_o, e.word));
        if (last_o !== e.lst) report($sformatf("last %b exp %b", last_o, e.lst));
      end
    end
  end

  always @(negedge clk_i) begin
    int r;
    r = $urandom_range(0, 99);
    if (pop_hold > 0) begin
      pop_hold <= pop_hold - 1;
      pop <= 1'b0;
    end else if (r < 75) begin
      pop <= 1'b1;
    end else begin
      pop <= 1'b0;
      pop_hold <= (r < 97) ? $urandom_range(0, 2) : $urandom_range(20, 300);
    end
  end

  function automatic logic [63:0] scaled(input logic [63:0] raw, input logic [62:0] s);
    logic signed [63:0] d;
    d = (s == 0) ? 64'sd1 : $signed({1'b0, s});
    return $signed(raw) / d;
  endfunction

  function automatic logic [63:0] zz(input logic [63:0] v);
    return {v[62:0], 1'b0} ^ {64{v[63]}};
  endfunction

  task automatic add(input logic [2:0] s, input logic [7:0] b, input logic [63:0] w);
    coded_t c;
    c.sid = s; c.byte_v = b; c.word = w; c.lst = 1'b0;
    coded_q = {coded_q, c};
  endtask

  task automatic add_varint(input logic [2:0] s, input logic [63:0] v);
    while (v >= 64'h80) begin
      add(s, {1'b1, v[6:0]}, 64'd0);
      v = v >> 7;
    end
    add(s, v[7:0], 64'd0);
  endtask

  task automatic predict_record(input logic [63:0] bp, ba, ap, aa, st, input logic fr, fn);
    logic [63:0] ts, b, spr, bq, aq;
    logic [3:0] m;
    int n0;
    n0 = coded_q.size();
    ts = scaled(st, k_time); b = scaled(bp, k_price); spr = scaled(ap - bp, k_price);
    bq = scaled(ba, k_qty); aq = scaled(aa, k_qty);
    if (fr) begin
      p_wait = 1'b0; p_nib = 4'd0;
      add(qdme_pkg::SID_BASE, 8'd0, ts);
      add(qdme_pkg::SID_BASE, 8'd0, b);
      add(qdme_pkg::SID_BASE, 8'd0, spr);
      add(qdme_pkg::SID_BASE, 8'd0, bq);
      add(qdme_pkg::SID_BASE, 8'd0, aq);
    end else begin
      add_varint(qdme_pkg::SID_TIME, ts - p_time);
      m = {aq != p_aq, bq != p_bq, spr != p_spr, b != p_bid};
      if (k_packed) begin
        if (!p_wait) begin p_nib = m; p_wait = 1'b1; end
        else begin
          add(qdme_pkg::SID_MASK, {m, p_nib}, 64'd0);
          p_nib = 4'd0; p_wait = 1'b0;
        end
      end else add(qdme_pkg::SID_MASK, {4'h0, m}, 64'd0);
      if (m[0]) add_varint(qdme_pkg::SID_BID, zz(b - p_bid));
      if (m[1]) add_varint(qdme_pkg::SID_SPREAD, zz(spr - p_spr));
      if (m[2]) add_varint(qdme_pkg::SID_BID_QTY, zz(bq - p_bq));
      if (m[3]) add_varint(qdme_pkg::SID_ASK_QTY, zz(aq - p_aq));
      if (fn && p_wait) begin
        add(qdme_pkg::SID_MASK, {4'h0, p_nib}, 64'd0);
        p_nib = 4'd0; p_wait = 1'b0;
      end
    end
    p_time = ts; p_bid = b; p_spr = spr; p_bq = bq; p_aq = aq;
    if (coded_q.size() > n0) coded_q[coded_q.size()-1].lst = 1'b1;
  endtask

  task automatic idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return;
    push <= 1'b0;
    repeat (r < 92 ? $urandom_range(1, 3) : $urandom_range(10, 400)) @(negedge clk_i);
  endtask

  task automatic send_record(input logic [63:0] bp, ba, ap, aa, st, input logic fr, fn);
    bid_price_i <= bp; bid_amount_i <= ba; ask_price_i <= ap; ask_amount_i <= aa;
    stamp_i <= st; first_record_i <= fr; final_record_i <= fn; push <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_record(bp, ba, ap, aa, st, fr, fn);
    @(negedge clk_i);
    idle_gap();
  endtask

  task automatic drain();
    push <= 1'b0;
    while (coded_q.size() != 0) @(negedge clk_i);
    repeat (800) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] v);
    cfg_index_i <= idx; cfg_data_i <= v; cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      qdme_pkg::REG_TIME_SCALE: k_time = v[62:0];
      qdme_pkg::REG_PRICE_SCALE: k_price = v[62:0];
      qdme_pkg::REG_QTY_SCALE: k_qty = v[62:0];
      qdme_pkg::REG_PACKED_MASKS: k_packed = v[0];
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_scales(input logic [63:0] t, p, q, input logic pk);
    drain();
    write_reg(qdme_pkg::REG_TIME_SCALE, t);
    write_reg(qdme_pkg::REG_PRICE_SCALE, p);
    write_reg(qdme_pkg::REG_QTY_SCALE, q);
    write_reg(qdme_pkg::REG_PACKED_MASKS, {63'b0, pk});
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] near(input logic [63:0] base);
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return base;
    if (r < 8) return base + $signed($urandom_range(0, 400)) - 200;
    if (r < 9) return base + {{32{1'b0}}, $urandom};
    return rnd64();
  endfunction

  task automatic test_directed();
    logic [63:0] mx, mn;
    mx = 64'h7fff_ffff_ffff_ffff; mn = 64'h8000_0000_0000_0000;
    send_record(10, 20, 30, 40, 50, 0, 0);
    send_record(mx, mx, mn, mn, mx, 1, 1);
    send_record(mn, mn, mx, mx, mn, 0, 0);
    send_record(mn, mn, mx, mx, mn, 0, 1);
    send_record(-1, -1, -1, -1, -1, 0, 0);
    send_record(0, 0, 0, 0, 0, 1, 0);
    send_record(127, 63, 127, 64, 128, 0, 0);
    drain();
    write_reg(qdme_pkg::REG_PACKED_MASKS, 1);
    send_record(-5, 3, 7, 9, 100, 0, 0);
    send_record(-5, 4, 7, 9, 90, 0, 0);
    send_record(-6, 4, 8, 9, 95, 0, 1);
    send_record(-6, 4, 8, 9, 95, 0, 0);
    send_record(1, 1, 1, 1, 1, 1, 1);
    send_record(2, 2, 2, 2, 2, 0, 0);
    drain();
    write_reg(qdme_pkg::REG_PACKED_MASKS, 0);
    send_record(3, 3, 3, 3, 3, 0, 0);
    drain();
    write_reg(qdme_pkg::REG_PACKED_MASKS, 1);
    send_record(3, 3, 3, 9, 3, 0, 0);
    send_record(3, 3, 3, 9, 3, 0, 1);
  endtask

  task automatic test_zero_and_max_scales();
    set_scales(0, 0, 0, 0);
    send_record(-7, 7, 9, -9, 11, 0, 0);
    set_scales(64'h7fff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffff, 1);
    send_record(64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000, -1, 64'h7fff_ffff_ffff_ffff,
                64'h8000_0000_0000_0000, 0, 0);
    send_record(64'h8000_0000_0000_0000, 1, 64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0001,
                64'h7fff_ffff_ffff_ffff, 0, 1);
  endtask

  task automatic run_blocks(input int count);
    logic [63:0] bp, ba, ap, aa;
    int blen, i;
    for (int n = 0; n < count; ) begin
      blen = $urandom_range(1, 12);
      bp = rnd64() >> $urandom_range(0, 60); ba = rnd64() >> $urandom_range(0, 60);
      ap = bp + $urandom_range(0, 50); aa = rnd64() >> $urandom_range(0, 60);
      for (i = 0; i < blen && n < count; i++, n++) begin
        if ($urandom_range(0, 19) == 0) begin
          send_record(rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), $urandom_range(0, 1),
                      $urandom_range(0, 1));
        end else begin
          bp = near(bp); ba = near(ba); ap = near(ap); aa = near(aa);
          stamp_run = ($urandom_range(0, 29) == 0) ? rnd64() :
                      stamp_run + $urandom_range(0, 3000);
          send_record(bp, ba, ap, aa, stamp_run, i == 0, i == blen - 1);
        end
      end
    end
  endtask

  task automatic test_random();
    set_scales(1, 1, 1, 0);          run_blocks(90);
    set_scales(1000, 10, 3, 1);      run_blocks(90);
    set_scales(7, 1, 1000000, 1);    run_blocks(90);
    set_scales($urandom_range(1, 99), $urandom_range(1, 99), $urandom_range(1, 99), 0);
    run_blocks(70);
    set_scales(rnd64() >> 1, 2, rnd64() >> 20, 1);
    run_blocks(60);
  endtask

  initial begin
    k_time = 1; k_price = 1; k_qty = 1; k_packed = 0;
    p_time = 0; p_bid = 0; p_spr = 0; p_bq = 0; p_aq = 0; p_nib = 0; p_wait = 0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_zero_and_max_scales();
    test_random();
    drain();
    if (errors == 0 && coded_q.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

>>> filelist.f
design/qdme_pkg.sv
design/qdme_div.sv
design/qdme_front.sv
design/qdme_queue.sv
design/qdme_back.sv
design/quote_delta_mask_encoder_core.sv
tb/tb_quote_delta_mask_encoder_core.sv
